// ===== src/md5_pkg.sv =====
// Package for the MD5 digest block: round constants, rotation amounts and
// shared types. No dependencies.
`default_nettype none
package md5_pkg;

    localparam logic [31:0] C_INIT_A = 32'h67452301;
    localparam logic [31:0] C_INIT_B = 32'hefcdab89;
    localparam logic [31:0] C_INIT_C = 32'h98badcfe;
    localparam logic [31:0] C_INIT_D = 32'h10325476;
    localparam logic [7:0]  C_PAD_BYTE = 8'b10000000;
    localparam logic [5:0]  C_LEN_POS = 6'd56;

    typedef logic [31:0] t_word;

    // Write request to the block memory.
    typedef struct packed {
        logic       en;
        logic [3:0] addr;
        t_word      data;
    } t_mem_wr;

    function automatic t_word sine_k(input logic [5:0] i);
        t_word k;
        unique case (i)
            6'd0:  k = 32'hd76aa478; 6'd1:  k = 32'he8c7b756;
            6'd2:  k = 32'h242070db; 6'd3:  k = 32'hc1bdceee;
            6'd4:  k = 32'hf57c0faf; 6'd5:  k = 32'h4787c62a;
            6'd6:  k = 32'ha8304613; 6'd7:  k = 32'hfd469501;
            6'd8:  k = 32'h698098d8; 6'd9:  k = 32'h8b44f7af;
            6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
            6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193;
            6'd14: k = 32'ha679438e; 6'd15: k = 32'h49b40821;
            6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
            6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa;
            6'd20: k = 32'hd62f105d; 6'd21: k = 32'h02441453;
            6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
            6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6;
            6'd26: k = 32'hf4d50d87; 6'd27: k = 32'h455a14ed;
            6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
            6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a;
            6'd32: k = 32'hfffa3942; 6'd33: k = 32'h8771f681;
            6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
            6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9;
            6'd38: k = 32'hf6bb4b60; 6'd39: k = 32'hbebfbc70;
            6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
            6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05;
            6'd44: k = 32'hd9d4d039; 6'd45: k = 32'he6db99e5;
            6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
            6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97;
            6'd50: k = 32'hab9423a7; 6'd51: k = 32'hfc93a039;
            6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
            6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1;
            6'd56: k = 32'h6fa87e4f; 6'd57: k = 32'hfe2ce6e0;
            6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
            6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235;
            6'd62: k = 32'h2ad7d2bb; default: k = 32'heb86d391;
        endcase
        return k;
    endfunction

    function automatic logic [4:0] rot_s(input logic [5:0] i);
        logic [4:0] s;
        unique case ({i[5:4], i[1:0]})
            4'd0:  s = 5'd7;  4'd1:  s = 5'd12; 4'd2:  s = 5'd17; 4'd3:  s = 5'd22;
            4'd4:  s = 5'd5;  4'd5:  s = 5'd9;  4'd6:  s = 5'd14; 4'd7:  s = 5'd20;
            4'd8:  s = 5'd4;  4'd9:  s = 5'd11; 4'd10: s = 5'd16; 4'd11: s = 5'd23;
            4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; default: s = 5'd21;
        endcase
        return s;
    endfunction

    // Message word used by round step i.
    function automatic logic [3:0] msg_idx(input logic [5:0] i);
        logic [3:0] g;
        unique case (i[5:4])
            2'd0: g = i[3:0];
            2'd1: g = 4'(5 * i[3:0] + 1);
            2'd2: g = 4'(3 * i[3:0] + 5);
            default: g = 4'(7 * i[3:0]);
        endcase
        return g;
    endfunction

endpackage
`default_nettype wire

// ===== src/md5_round.sv =====
// One MD5 round step per cycle while i_step is high, over the working registers a..d.
// Depends on md5_pkg.
`default_nettype none
module md5_round (
    input  wire             i_clk,
    input  wire             i_load,
    input  md5_pkg::t_word  i_a,
    input  md5_pkg::t_word  i_b,
    input  md5_pkg::t_word  i_c,
    input  md5_pkg::t_word  i_d,
    input  wire             i_step,
    input  wire [5:0]       i_idx,
    input  md5_pkg::t_word  i_m,
    output md5_pkg::t_word  o_a,
    output md5_pkg::t_word  o_b,
    output md5_pkg::t_word  o_c,
    output md5_pkg::t_word  o_d
);
    import md5_pkg::*;

    t_word r_a, r_b, r_c, r_d;
    t_word f, t, rot;
    logic [4:0] s;

    always_comb begin
        unique case (i_idx[5:4])
            2'd0: f = (r_b & r_c) | (~r_b & r_d);
            2'd1: f = (r_b & r_d) | (r_c & ~r_d);
            2'd2: f = r_b ^ r_c ^ r_d;
            default: f = r_c ^ (r_b | ~r_d);
        endcase
        t = r_a + f + i_m + sine_k(i_idx);
        s = rot_s(i_idx);
        rot = (t << s) | (t >> (6'd32 - {1'b0, s}));
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_a <= i_a; r_b <= i_b; r_c <= i_c; r_d <= i_d;
        end else if (i_step) begin
            r_a <= r_d; r_d <= r_c; r_c <= r_b; r_b <= r_b + rot;
        end
    end

    assign o_a = r_a;
    assign o_b = r_b;
    assign o_c = r_c;
    assign o_d = r_d;
endmodule
`default_nettype wire

// ===== src/md5_block_mem.sv =====
// The 16-word message block memory, with a registered (synchronous) read.
// Depends on md5_pkg.
`default_nettype none
module md5_block_mem (
    input  wire              i_clk,
    input  md5_pkg::t_mem_wr i_wr,
    input  wire [3:0]        i_raddr,
    output md5_pkg::t_word   o_rdata
);
    import md5_pkg::*;

    t_word mem [16];
    t_word r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            mem[i_wr.addr] <= i_wr.data;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

// ===== src/md5_message_digest.sv =====
// MD5 digest top level: byte packing, padding sequencer, round control, output.
// Depends on md5_pkg, md5_block_mem and md5_round.
//
//  channel | direction | ports
//  in      | sink      | i_valid, o_ready, i_data_byte, i_has_byte, i_end_of_message
//  out     | source    | o_valid, i_ready, o_digest_word, o_word_index, o_last_word
//
// A byte is accepted in idle and packed into a holding word in the byte state,
// and no new byte is taken until then; every fourth byte writes that word to
// the block memory. The round unit runs one step a cycle over a full block,
// after a memory prefetch, and ends with the final chaining add.
// The end marker pads one byte a cycle and may run two blocks, then the four
// words leave from the chaining registers, one per accepted word.
// Reset restores the chaining constants; the block memory is not cleared.
`default_nettype none
module md5_message_digest (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_valid,
    output logic        o_ready,
    input  wire  [7:0]  i_data_byte,
    input  wire         i_has_byte,
    input  wire         i_end_of_message,
    output logic        o_valid,
    input  wire         i_ready,
    output logic [31:0] o_digest_word,
    output logic [1:0]  o_word_index,
    output logic        o_last_word
);
    import md5_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_BYTE  = 7'b0000010,
        S_PAD   = 7'b0000100,
        S_LEN   = 7'b0001000,
        S_ROUND = 7'b0010000,
        S_ADD   = 7'b0100000,
        S_OUT   = 7'b1000000
    } t_state;

    t_state      r_state, n_state;
    t_word       r_ch [4];
    logic [5:0]  r_fill;
    logic [63:0] r_bits;
    t_word       r_hold;
    logic [7:0]  r_byte;
    logic        r_fin, r_lenhi;
    logic [6:0]  r_step;
    logic [1:0]  r_oidx;

    t_mem_wr     wr;
    logic [3:0]  raddr;
    t_word       rdata;
    t_word       wa, wb, wc, wd;
    logic        rload, rstep;
    t_word       packed_w;

    md5_block_mem u_mem (.i_clk(i_clk), .i_wr(wr), .i_raddr(raddr), .o_rdata(rdata));
    md5_round u_round (
        .i_clk(i_clk), .i_load(rload), .i_a(r_ch[0]), .i_b(r_ch[1]), .i_c(r_ch[2]),
        .i_d(r_ch[3]), .i_step(rstep), .i_idx(r_step[5:0] - 6'd1), .i_m(rdata),
        .o_a(wa), .o_b(wb), .o_c(wc), .o_d(wd)
    );

    assign o_ready = (r_state == S_IDLE);

    always_comb begin
        unique case (r_fill[1:0])
            2'd0: packed_w = {24'd0, r_byte};
            2'd1: packed_w = {16'd0, r_byte, r_hold[7:0]};
            2'd2: packed_w = {8'd0, r_byte, r_hold[15:0]};
            default: packed_w = {r_byte, r_hold[23:0]};
        endcase
    end

    // r_step 0 presents address of step 0; step k of the round uses the read
    // data whose address was issued in the cycle before.
    always_comb begin
        wr = '0;
        rload = 1'b0;
        rstep = 1'b0;
        raddr = msg_idx(r_step[5:0]);
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid && i_has_byte) begin
                    n_state = S_BYTE;
                end else if (i_valid && i_end_of_message) begin
                    n_state = S_PAD;
                end
            end
            S_BYTE, S_PAD: begin
                wr.en = (r_fill[1:0] == 2'd3);
                wr.addr = r_fill[5:2];
                wr.data = packed_w;
                if (r_fill == 6'd63) begin
                    n_state = S_ROUND;
                    rload = 1'b1;
                end else if (r_state == S_BYTE) begin
                    n_state = r_fin ? S_PAD : S_IDLE;
                end else if (r_fill == C_LEN_POS - 6'd1) begin
                    n_state = S_LEN;
                end
            end
            S_LEN: begin
                wr.en = 1'b1;
                wr.addr = r_lenhi ? 4'd15 : 4'd14;
                wr.data = r_lenhi ? r_bits[63:32] : r_bits[31:0];
                if (r_lenhi) begin
                    n_state = S_ROUND;
                    rload = 1'b1;
                end
            end
            S_ROUND: begin
                rstep = (r_step != 7'd0);
                if (r_step == 7'd64) begin
                    n_state = S_ADD;
                end
            end
            S_ADD: begin
                if (!r_fin) begin
                    n_state = S_IDLE;
                end else if (r_lenhi) begin
                    n_state = S_OUT;
                end else begin
                    n_state = S_PAD;
                end
            end
            S_OUT: begin
                if (i_ready && r_oidx == 2'd3) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ch[0] <= C_INIT_A; r_ch[1] <= C_INIT_B;
            r_ch[2] <= C_INIT_C; r_ch[3] <= C_INIT_D;
            r_fill <= '0;
            r_bits <= '0;
            r_fin <= 1'b0;
            r_lenhi <= 1'b0;
            r_step <= '0;
            r_oidx <= '0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                S_IDLE: begin
                    r_fin <= i_end_of_message;
                    r_lenhi <= 1'b0;
                    r_byte <= i_has_byte ? i_data_byte : C_PAD_BYTE;
                    if (i_valid && i_has_byte) begin
                        r_bits <= r_bits + 64'd8;
                    end
                end
                S_BYTE, S_PAD: begin
                    r_hold <= packed_w;
                    r_fill <= r_fill + 6'd1;
                    r_step <= '0;
                    // After the marker byte every further pad byte is zero.
                    r_byte <= (r_state == S_BYTE) ? C_PAD_BYTE : 8'd0;
                end
                S_LEN: begin
                    r_lenhi <= 1'b1;
                    r_step <= '0;
                end
                S_ROUND: begin
                    r_step <= r_step + 7'd1;
                end
                S_ADD: begin
                    r_ch[0] <= r_ch[0] + wa; r_ch[1] <= r_ch[1] + wb;
                    r_ch[2] <= r_ch[2] + wc; r_ch[3] <= r_ch[3] + wd;
                    r_fill <= '0;
                    r_oidx <= '0;
                end
                S_OUT: begin
                    if (i_ready) begin
                        r_oidx <= r_oidx + 2'd1;
                        if (r_oidx == 2'd3) begin
                            r_ch[0] <= C_INIT_A; r_ch[1] <= C_INIT_B;
                            r_ch[2] <= C_INIT_C; r_ch[3] <= C_INIT_D;
                            r_bits <= '0;
                            r_fill <= '0;
                            r_fin <= 1'b0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_valid = (r_state == S_OUT);
    assign o_digest_word = r_ch[r_oidx];
    assign o_word_index = r_oidx;
    assign o_last_word = (r_oidx == 2'd3);

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> !o_valid) else $error("input taken during output");
    a_round_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ADD) |-> $past(r_step) == 7'd64) else $error("short round");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> o_valid && $stable(o_word_index))
        else $error("digest word dropped");
endmodule
`default_nettype wire
